// File: rtl/cfa_pkg.sv
// Shared types and codes for the constant folding ALU.
package cfa_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;

    typedef logic [4:0] act_t;
    localparam act_t ACT_ADD    = 5'd0;
    localparam act_t ACT_SUB    = 5'd1;
    localparam act_t ACT_MUL    = 5'd2;
    localparam act_t ACT_DIV    = 5'd3;
    localparam act_t ACT_REM    = 5'd4;
    localparam act_t ACT_AND    = 5'd5;
    localparam act_t ACT_OR     = 5'd6;
    localparam act_t ACT_XOR    = 5'd7;
    localparam act_t ACT_SHL    = 5'd8;
    localparam act_t ACT_SHR    = 5'd9;
    localparam act_t ACT_EQ     = 5'd10;
    localparam act_t ACT_NE     = 5'd11;
    localparam act_t ACT_LT     = 5'd12;
    localparam act_t ACT_GT     = 5'd13;
    localparam act_t ACT_LE     = 5'd14;
    localparam act_t ACT_GE     = 5'd15;
    localparam act_t ACT_INVERT = 5'd16;
    localparam act_t ACT_LNOT   = 5'd17;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_INT_BIN  = 2'd0;
    localparam kind_t KIND_BOOL_BIN = 2'd1;
    localparam kind_t KIND_INT_UN   = 2'd2;
    localparam kind_t KIND_BOOL_UN  = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_FOLDED  = 2'd0;
    localparam status_t ST_NOFOLD  = 2'd1;
    localparam status_t ST_INVALID = 2'd2;
    localparam status_t ST_DIVZERO = 2'd3;

    typedef struct packed {
        logic        exec;
        act_t        act;
        status_t     status;
        logic        isb;
        logic [31:0] val;
        logic [31:0] lhs;
        logic [31:0] rhs;
    } cfa_entry_t;

endpackage

// File: rtl/cfa_front.sv
// Front end: classify a word and settle everything but two-constant integer work.
module cfa_front
    import cfa_pkg::*;
(
    input  act_t        action,
    input  kind_t       operand_kind,
    input  logic        lhs_known,
    input  logic [31:0] lhs_value,
    input  logic        rhs_known,
    input  logic [31:0] rhs_value,
    output cfa_entry_t  entry
);

    logic lb, rb, lmin, lmax, rmin, rmax, lzero, rzero;

    always_comb
    begin
        lb    = lhs_value != 32'd0;
        rb    = rhs_value != 32'd0;
        lzero = lhs_known && !lb;
        rzero = rhs_known && !rb;
        lmin  = lhs_known && lhs_value == WORD_MIN;
        lmax  = lhs_known && lhs_value == WORD_MAX;
        rmin  = rhs_known && rhs_value == WORD_MIN;
        rmax  = rhs_known && rhs_value == WORD_MAX;

        entry.exec   = 1'b0;
        entry.act    = action;
        entry.status = ST_NOFOLD;
        entry.isb    = 1'b0;
        entry.val    = 32'd0;
        entry.lhs    = lhs_value;
        entry.rhs    = rhs_value;

        unique case (operand_kind)
            KIND_INT_BIN:
            begin
                if (action > ACT_GE)
                begin
                    entry.status = ST_INVALID;
                end
                else if (lhs_known && rhs_known)
                begin
                    if ((action == ACT_DIV || action == ACT_REM) && !rb)
                    begin
                        entry.status = ST_DIVZERO;
                    end
                    else if ((action == ACT_DIV || action == ACT_REM)
                             && lhs_value == WORD_MIN && rhs_value == 32'hFFFF_FFFF)
                    begin
                        // wrap the one overflowing quotient
                        entry.status = ST_FOLDED;
                        entry.val    = (action == ACT_DIV) ? WORD_MIN : 32'd0;
                    end
                    else
                    begin
                        entry.exec   = 1'b1;
                        entry.status = ST_FOLDED;
                        entry.isb    = action >= ACT_EQ;
                    end
                end
                else if (lhs_known || rhs_known)
                begin
                    unique case (action)
                        ACT_MUL, ACT_AND:
                            if (lzero || rzero)
                                entry.status = ST_FOLDED;
                        ACT_DIV, ACT_REM:
                            if (lzero)
                                entry.status = ST_FOLDED;
                        ACT_LE:
                            if (lmin || rmax)
                            begin
                                entry.status = ST_FOLDED;
                                entry.isb    = 1'b1;
                                entry.val    = 32'd1;
                            end
                        ACT_GE:
                            if (lmax || rmin)
                            begin
                                entry.status = ST_FOLDED;
                                entry.isb    = 1'b1;
                                entry.val    = 32'd1;
                            end
                        ACT_LT:
                            if (lmax || rmin)
                            begin
                                entry.status = ST_FOLDED;
                                entry.isb    = 1'b1;
                            end
                        ACT_GT:
                            if (lmin || rmax)
                            begin
                                entry.status = ST_FOLDED;
                                entry.isb    = 1'b1;
                            end
                        default:
                            entry.status = ST_NOFOLD;
                    endcase
                end
            end
            KIND_BOOL_BIN:
            begin
                if (action != ACT_AND && action != ACT_OR
                    && action != ACT_EQ && action != ACT_NE)
                begin
                    entry.status = ST_INVALID;
                end
                else if (lhs_known && rhs_known)
                begin
                    entry.status = ST_FOLDED;
                    entry.isb    = 1'b1;
                    unique case (action)
                        ACT_AND: entry.val = {31'd0, lb && rb};
                        ACT_OR:  entry.val = {31'd0, lb || rb};
                        ACT_EQ:  entry.val = {31'd0, lb == rb};
                        default: entry.val = {31'd0, lb != rb};
                    endcase
                end
                else if (action == ACT_AND && (lzero || rzero))
                begin
                    entry.status = ST_FOLDED;
                    entry.isb    = 1'b1;
                end
                else if (action == ACT_OR
                         && ((lhs_known && lb) || (rhs_known && rb)))
                begin
                    entry.status = ST_FOLDED;
                    entry.isb    = 1'b1;
                    entry.val    = 32'd1;
                end
            end
            KIND_INT_UN:
            begin
                if (action != ACT_ADD && action != ACT_SUB && action != ACT_INVERT)
                begin
                    entry.status = ST_INVALID;
                end
                else if (lhs_known)
                begin
                    entry.status = ST_FOLDED;
                    if (action == ACT_ADD)
                        entry.val = lhs_value;
                    else if (action == ACT_SUB)
                        entry.val = 32'd0 - lhs_value;
                    else
                        entry.val = ~lhs_value;
                end
            end
            default:
            begin
                if (action != ACT_LNOT)
                begin
                    entry.status = ST_INVALID;
                end
                else if (lhs_known)
                begin
                    entry.status = ST_FOLDED;
                    entry.isb    = 1'b1;
                    entry.val    = {31'd0, !lb};
                end
            end
        endcase
    end

endmodule

// File: rtl/cfa_fifo.sv
// Short queue between the front and back ends.
module cfa_fifo
    import cfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cfa_entry_t wdata,
    input  logic       pop,
    output cfa_entry_t rdata,
    output logic       empty,
    output logic       full
);

    cfa_entry_t          mem [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign empty = cnt_reg == QCNT_W'(0);
    assign full  = cnt_reg == QCNT_W'(QDEPTH);
    assign rdata = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + QPTR_W'(1);
            if (pop)
                rptr_reg <= rptr_reg + QPTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

endmodule

// File: rtl/cfa_div.sv
// Signed 32-bit divider, one quotient bit per cycle.
module cfa_div
    import cfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quo,
    output logic [31:0] rem
);

    logic        run_reg, done_reg, negq_reg, negr_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg, quo_reg, dvs_reg;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};
    assign done  = done_reg;
    assign quo   = negq_reg ? 32'd0 - quo_reg : quo_reg;
    assign rem   = negr_reg ? 32'd0 - rem_reg : rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= 32'd0;
            quo_reg  <= dividend[31] ? 32'd0 - dividend : dividend;
            dvs_reg  <= divisor[31] ? 32'd0 - divisor : divisor;
            negq_reg <= dividend[31] ^ divisor[31];
            negr_reg <= dividend[31];
        end
        else if (run_reg)
        begin
            // restore when the trial goes negative
            rem_reg <= trial[32] ? {rem_reg[30:0], quo_reg[31]} : trial[31:0];
            quo_reg <= {quo_reg[30:0], !trial[32]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && cnt_reg == 5'd31;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    run_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/cfa_back.sv
// Back end: carry out queued words and drive the result register.
module cfa_back
    import cfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfa_entry_t  head,
    input  logic        empty,
    output logic        pop,
    output logic        done,
    output status_t     status,
    output logic        result_is_boolean,
    output logic [31:0] result_value
);

    typedef enum logic {S_RUN, S_DIV} state_t;

    state_t      state_reg;
    logic        done_reg, isb_reg, isrem_reg;
    status_t     status_reg;
    logic [31:0] value_reg;
    logic        is_div, div_start, div_done;
    logic [31:0] alu, quo, rem;
    logic signed [31:0] l, r;

    assign l         = head.lhs;
    assign r         = head.rhs;
    assign pop       = state_reg == S_RUN && !empty;
    assign is_div    = head.exec && (head.act == ACT_DIV || head.act == ACT_REM);
    assign div_start = pop && is_div;

    assign done              = done_reg;
    assign status            = status_reg;
    assign result_is_boolean = isb_reg;
    assign result_value      = value_reg;

    cfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (head.lhs),
        .divisor  (head.rhs),
        .done     (div_done),
        .quo      (quo),
        .rem      (rem)
    );

    always_comb
    begin
        unique case (head.act)
            ACT_ADD: alu = head.lhs + head.rhs;
            ACT_SUB: alu = head.lhs - head.rhs;
            ACT_MUL: alu = head.lhs * head.rhs;
            ACT_AND: alu = head.lhs & head.rhs;
            ACT_OR:  alu = head.lhs | head.rhs;
            ACT_XOR: alu = head.lhs ^ head.rhs;
            ACT_SHL: alu = head.lhs << head.rhs[4:0];
            ACT_SHR: alu = 32'(l >>> head.rhs[4:0]);
            ACT_EQ:  alu = {31'd0, l == r};
            ACT_NE:  alu = {31'd0, l != r};
            ACT_LT:  alu = {31'd0, l < r};
            ACT_GT:  alu = {31'd0, l > r};
            ACT_LE:  alu = {31'd0, l <= r};
            ACT_GE:  alu = {31'd0, l >= r};
            default: alu = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_RUN;
            done_reg   <= 1'b0;
            status_reg <= ST_FOLDED;
            isb_reg    <= 1'b0;
            value_reg  <= 32'd0;
            isrem_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (div_start)
                isrem_reg <= head.act == ACT_REM;
            unique case (state_reg)
                S_RUN:
                begin
                    if (div_start)
                    begin
                        state_reg <= S_DIV;
                    end
                    else if (pop)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= head.status;
                        isb_reg    <= head.isb;
                        value_reg  <= head.exec ? alu : head.val;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        done_reg   <= 1'b1;
                        state_reg  <= S_RUN;
                        status_reg <= ST_FOLDED;
                        isb_reg    <= 1'b0;
                        value_reg  <= isrem_reg ? rem : quo;
                    end
                end
                default:
                    state_reg <= S_RUN;
            endcase
        end
    end

endmodule

// File: rtl/constant_fold_alu.sv
// Top level of the constant folding ALU.
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  command  | start / busy     | action operand_kind lhs_known lhs_value
//           |                  | rhs_known rhs_value
//  result   | done (1 cycle)   | status result_is_boolean result_value
//
// Words are queued and each result is registered from the queue head onto the
// result ports. One word per cycle is sustained while the bit-serial divider is
// idle; a div or rem using it holds the back end while the four-entry queue
// keeps taking words and busy rises once it is full. The receiver cannot hold
// results off. Reset clears the queue, divider and result strobe.
module constant_fold_alu
    import cfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  action,
    input  logic [1:0]  operand_kind,
    input  logic        lhs_known,
    input  logic [31:0] lhs_value,
    input  logic        rhs_known,
    input  logic [31:0] rhs_value,
    output logic        done,
    output logic [1:0]  status,
    output logic        result_is_boolean,
    output logic [31:0] result_value
);

    cfa_entry_t entry, head;
    logic       push, pop, empty, full;

    assign busy = full;
    assign push = start && !full;

    cfa_front u_front (
        .action       (action),
        .operand_kind (operand_kind),
        .lhs_known    (lhs_known),
        .lhs_value    (lhs_value),
        .rhs_known    (rhs_known),
        .rhs_value    (rhs_value),
        .entry        (entry)
    );

    cfa_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (entry),
        .pop   (pop),
        .rdata (head),
        .empty (empty),
        .full  (full)
    );

    cfa_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .empty             (empty),
        .pop               (pop),
        .done              (done),
        .status            (status),
        .result_is_boolean (result_is_boolean),
        .result_value      (result_value)
    );

endmodule

// File: rtl/cfa_checker.sv
// Port-level checks on the constant folding ALU.
module cfa_checker
    import cfa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic [1:0]  status,
    input logic        result_is_boolean,
    input logic [31:0] result_value
);

    a_nofold_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_FOLDED |-> !result_is_boolean && result_value == 32'd0)
        else $error("unfolded word carries a value");

    a_bool_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && result_is_boolean |-> result_value[31:1] == 31'd0)
        else $error("boolean result out of range");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !done)
        else $error("result strobe straight after reset");

endmodule

bind constant_fold_alu cfa_checker u_cfa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .done              (done),
    .status            (status),
    .result_is_boolean (result_is_boolean),
    .result_value      (result_value)
);

// File: verif/constant_fold_alu_tb.sv
// Testbench for the constant folding ALU: directed table, then random words checked by a predictor.
`timescale 1ns / 1ps

module constant_fold_alu_tb;
    import cfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1630;

    typedef struct packed {
        status_t     st;
        logic        isb;
        logic [31:0] val;
    } fold_t;

    typedef struct {
        act_t        act;
        kind_t       kind;
        logic        lk;
        logic [31:0] lv;
        logic        rk;
        logic [31:0] rv;
        logic        typed;
        fold_t       want;
    } vec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [4:0]  action = '0;
    logic [1:0]  operand_kind = '0;
    logic        lhs_known = 1'b0;
    logic [31:0] lhs_value = '0;
    logic        rhs_known = 1'b0;
    logic [31:0] rhs_value = '0;
    logic        done;
    logic [1:0]  status;
    logic        result_is_boolean;
    logic [31:0] result_value;

    fold_t pending_folds[$];
    int    errors = 0;
    int    idle_cycles = 0;
    int    sender_idle_pct = 29;

    constant_fold_alu DUT (.*);

    always #6 clk = ~clk;

    function automatic fold_t mk(status_t st, logic isb, logic [31:0] val);
        fold_t f;
        f.st = st;
        f.isb = isb;
        f.val = val;
        return f;
    endfunction

    function automatic fold_t fold_int(act_t a, logic lk, logic [31:0] lu,
                                       logic rk, logic [31:0] ru);
        logic signed [31:0] l;
        logic signed [31:0] r;
        logic lmin, lmax, rmin, rmax;
        l = lu;
        r = ru;
        lmin = lk && lu == WORD_MIN;
        lmax = lk && lu == WORD_MAX;
        rmin = rk && ru == WORD_MIN;
        rmax = rk && ru == WORD_MAX;
        if (a > ACT_GE)
            return mk(ST_INVALID, 0, 0);
        if (!lk && !rk)
            return mk(ST_NOFOLD, 0, 0);
        if (lk && rk) begin
            case (a)
                ACT_ADD: return mk(ST_FOLDED, 0, lu + ru);
                ACT_SUB: return mk(ST_FOLDED, 0, lu - ru);
                ACT_MUL: return mk(ST_FOLDED, 0, lu * ru);
                ACT_DIV, ACT_REM: begin
                    if (ru == 0)
                        return mk(ST_DIVZERO, 0, 0);
                    if (lu == WORD_MIN && ru == '1)
                        return mk(ST_FOLDED, 0, a == ACT_DIV ? WORD_MIN : 32'd0);
                    return mk(ST_FOLDED, 0, a == ACT_DIV ? l / r : l % r);
                end
                ACT_AND: return mk(ST_FOLDED, 0, lu & ru);
                ACT_OR:  return mk(ST_FOLDED, 0, lu | ru);
                ACT_XOR: return mk(ST_FOLDED, 0, lu ^ ru);
                ACT_SHL: return mk(ST_FOLDED, 0, lu << ru[4:0]);
                ACT_SHR: return mk(ST_FOLDED, 0, l >>> ru[4:0]);
                ACT_EQ:  return mk(ST_FOLDED, 1, l == r);
                ACT_NE:  return mk(ST_FOLDED, 1, l != r);
                ACT_LT:  return mk(ST_FOLDED, 1, l < r);
                ACT_GT:  return mk(ST_FOLDED, 1, l > r);
                ACT_LE:  return mk(ST_FOLDED, 1, l <= r);
                default: return mk(ST_FOLDED, 1, l >= r);
            endcase
        end
        case (a)
            ACT_MUL, ACT_AND:
                if ((lk && lu == 0) || (rk && ru == 0)) return mk(ST_FOLDED, 0, 0);
            ACT_DIV, ACT_REM:
                if (lk && lu == 0) return mk(ST_FOLDED, 0, 0);
            ACT_LE: if (lmin || rmax) return mk(ST_FOLDED, 1, 1);
            ACT_GE: if (lmax || rmin) return mk(ST_FOLDED, 1, 1);
            ACT_LT: if (lmax || rmin) return mk(ST_FOLDED, 1, 0);
            ACT_GT: if (lmin || rmax) return mk(ST_FOLDED, 1, 0);
            default: ;
        endcase
        return mk(ST_NOFOLD, 0, 0);
    endfunction

    function automatic fold_t fold_word(act_t a, kind_t k, logic lk, logic [31:0] lu,
                                        logic rk, logic [31:0] ru);
        logic lb, rb;
        lb = lu != 0;
        rb = ru != 0;
        case (k)
            KIND_INT_BIN: return fold_int(a, lk, lu, rk, ru);
            KIND_BOOL_BIN: begin
                if (a != ACT_AND && a != ACT_OR && a != ACT_EQ && a != ACT_NE)
                    return mk(ST_INVALID, 0, 0);
                if (!lk && !rk)
                    return mk(ST_NOFOLD, 0, 0);
                if (lk && rk) begin
                    case (a)
                        ACT_AND: return mk(ST_FOLDED, 1, lb && rb);
                        ACT_OR:  return mk(ST_FOLDED, 1, lb || rb);
                        ACT_EQ:  return mk(ST_FOLDED, 1, lb == rb);
                        default: return mk(ST_FOLDED, 1, lb != rb);
                    endcase
                end
                if (a == ACT_AND && ((lk && !lb) || (rk && !rb)))
                    return mk(ST_FOLDED, 1, 0);
                if (a == ACT_OR && ((lk && lb) || (rk && rb)))
                    return mk(ST_FOLDED, 1, 1);
                return mk(ST_NOFOLD, 0, 0);
            end
            KIND_INT_UN: begin
                if (a != ACT_ADD && a != ACT_SUB && a != ACT_INVERT)
                    return mk(ST_INVALID, 0, 0);
                if (!lk)
                    return mk(ST_NOFOLD, 0, 0);
                if (a == ACT_ADD) return mk(ST_FOLDED, 0, lu);
                if (a == ACT_SUB) return mk(ST_FOLDED, 0, 32'd0 - lu);
                return mk(ST_FOLDED, 0, ~lu);
            end
            default: begin
                if (a != ACT_LNOT)
                    return mk(ST_INVALID, 0, 0);
                if (!lk)
                    return mk(ST_NOFOLD, 0, 0);
                return mk(ST_FOLDED, 1, lu == 0);
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4: return 32'd1;
            5: return $urandom_range(0, 40);
            6: return 32'd0 - $urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    // Drive one word and hold it until taken.
    task automatic send(act_t a, kind_t k, logic lk, logic [31:0] lv,
                        logic rk, logic [31:0] rv, logic typed, fold_t want);
        fold_t f;
        f = fold_word(a, k, lk, lv, rk, rv);
        if (typed && f != want)
        begin
            $display("%0t table row disagrees with predictor: expected %h actual %h",
                     $time, want, f);
            errors++;
        end
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        action <= a;
        operand_kind <= k;
        lhs_known <= lk;
        lhs_value <= lv;
        rhs_known <= rk;
        rhs_value <= rv;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_folds.push_back(typed ? want : f);
    endtask

    always @(posedge clk)
    begin
        fold_t w;
        if (done)
        begin
            if (pending_folds.size() == 0)
            begin
                $display("%0t unexpected word: expected none actual %h %b %h", $time,
                         status, result_is_boolean, result_value);
                errors++;
            end
            else
            begin
                w = pending_folds.pop_front();
                if (status !== w.st || result_is_boolean !== w.isb ||
                    result_value !== w.val)
                begin
                    $display("%0t mismatch: expected %h %b %h actual %h %b %h", $time,
                             w.st, w.isb, w.val, status, result_is_boolean, result_value);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving in either direction.
    always @(posedge clk)
    begin
        if (done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        vec_t tbl[$];
        vec_t v;
        int   n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tbl = '{
            '{ACT_ADD, KIND_INT_BIN, 1, WORD_MAX, 1, 32'd1, 1, '{ST_FOLDED, 1'b0, WORD_MIN}},
            '{ACT_SUB, KIND_INT_BIN, 1, WORD_MIN, 1, 32'd1, 1, '{ST_FOLDED, 1'b0, WORD_MAX}},
            '{ACT_MUL, KIND_INT_BIN, 1, WORD_MAX, 1, 32'd7, 0, '{ST_FOLDED, 1'b0, 32'd0}},
            '{ACT_DIV, KIND_INT_BIN, 1, 32'd9, 1, 32'd0, 1, '{ST_DIVZERO, 1'b0, 32'd0}},
            '{ACT_REM, KIND_INT_BIN, 1, 32'd9, 1, 32'd0, 1, '{ST_DIVZERO, 1'b0, 32'd0}},
            '{ACT_DIV, KIND_INT_BIN, 1, WORD_MIN, 1, '1, 1, '{ST_FOLDED, 1'b0, WORD_MIN}},
            '{ACT_REM, KIND_INT_BIN, 1, WORD_MIN, 1, '1, 1, '{ST_FOLDED, 1'b0, 32'd0}},
            '{ACT_DIV, KIND_INT_BIN, 1, -32'sd7, 1, 32'd2, 0, '{ST_FOLDED, 1'b0, 32'd0}},
            '{ACT_REM, KIND_INT_BIN, 1, -32'sd7, 1, 32'd2, 0, '{ST_FOLDED, 1'b0, 32'd0}},
            '{ACT_AND, KIND_INT_BIN, 1, '1, 1, 32'h0F0F, 0, '{ST_FOLDED, 1'b0, 32'd0}},
            '{ACT_OR, KIND_INT_BIN, 1, 32'h1234, 1, 32'h8000, 0, '{ST_FOLDED, 1'b0, 32'd0}},
            '{ACT_XOR, KIND_INT_BIN, 1, '1, 1, 32'h5555, 0, '{ST_FOLDED, 1'b0, 32'd0}},
            '{ACT_SHL, KIND_INT_BIN, 1, 32'd1, 1, 32'd33, 1, '{ST_FOLDED, 1'b0, 32'd2}},
            '{ACT_SHR, KIND_INT_BIN, 1, WORD_MIN, 1, 32'd31, 1, '{ST_FOLDED, 1'b0, '1}},
            '{ACT_LT, KIND_INT_BIN, 1, WORD_MIN, 1, WORD_MAX, 1, '{ST_FOLDED, 1'b1, 32'd1}},
            '{ACT_GE, KIND_INT_BIN, 1, WORD_MIN, 1, WORD_MAX, 1, '{ST_FOLDED, 1'b1, 32'd0}},
            '{ACT_MUL, KIND_INT_BIN, 0, 32'd5, 1, 32'd0, 1, '{ST_FOLDED, 1'b0, 32'd0}},
            '{ACT_LE, KIND_INT_BIN, 1, WORD_MIN, 0, 32'd3, 1, '{ST_FOLDED, 1'b1, 32'd1}},
            '{ACT_GT, KIND_INT_BIN, 0, 32'd3, 1, WORD_MAX, 1, '{ST_FOLDED, 1'b1, 32'd0}},
            '{ACT_ADD, KIND_INT_BIN, 0, 32'd1, 0, 32'd2, 1, '{ST_NOFOLD, 1'b0, 32'd0}},
            '{ACT_LNOT, KIND_INT_BIN, 1, 32'd1, 1, 32'd2, 1, '{ST_INVALID, 1'b0, 32'd0}},
            '{ACT_OR, KIND_BOOL_BIN, 0, 32'd0, 1, 32'd5, 1, '{ST_FOLDED, 1'b1, 32'd1}},
            '{ACT_XOR, KIND_BOOL_BIN, 1, 32'd1, 1, 32'd1, 1, '{ST_INVALID, 1'b0, 32'd0}},
            '{ACT_SUB, KIND_INT_UN, 1, WORD_MIN, 0, 32'd0, 1, '{ST_FOLDED, 1'b0, WORD_MIN}},
            '{ACT_LNOT, KIND_BOOL_UN, 1, 32'd0, 0, 32'd0, 1, '{ST_FOLDED, 1'b1, 32'd1}}
        };
        foreach (tbl[i])
        begin
            v = tbl[i];
            send(v.act, v.kind, v.lk, v.lv, v.rk, v.rv, v.typed, v.want);
        end

        // Hold off until the back end has drained.
        start <= 1'b0;
        while (pending_folds.size() != 0)
            @(posedge clk);

        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 3)
                sender_idle_pct = 59;
            else if (n == 2 * RANDOM_WORDS / 3)
                sender_idle_pct = 0;
            send(($urandom_range(0, 9) == 0) ? act_t'($urandom_range(18, 31))
                                             : act_t'($urandom_range(0, 17)),
                 kind_t'($urandom_range(0, 3)), $urandom_range(0, 3) != 0,
                 pick_operand(), $urandom_range(0, 3) != 0, pick_operand(), 0, '0);
        end

        start <= 1'b0;
        while (pending_folds.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
